>>> rtl/qs_pkg.sv
// qs_pkg: shared constants and beat types for the quicksort engine
// no dependencies; imported by every module of the block but qs_ram
package qs_pkg;

    localparam int MAX_ELEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_ELEMS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int STK_W      = 2 * IDX_W;

    // input beat
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last_element;
    } item_t;

    // output beat
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         last_result;
    } result_t;

    // handoff from the front queue to the back end
    typedef struct packed {
        logic  valid;
        item_t data;
    } queue_head_t;

endpackage

>>> rtl/quicksort_engine.sv
// quicksort_engine: top level, input queue in front of the sorting back end
// depends on qs_pkg, qs_front, qs_back (and qs_ram through qs_back)
//
// usage:
//   item channel (item_valid, item_stall, item) takes one signed element per
//   beat; the beat with last_element set closes the set. Up to 64 elements
//   are kept; extra beats are dropped, but a last one still closes the set.
//   result channel (result_valid, result_stall, result) returns the set in
//   ascending order, last_result set on the final beat.
// timing:
//   loading takes one element per cycle while the back end is idle; a
//   two-beat queue absorbs input while it is busy, then item_stall rises.
//   sorting is a state machine around the element ram's read and write
//   ports: each scan step reads an element and compares it to the pivot, a
//   swap writes both elements, and each partition also pops its range,
//   reads the pivot, places it and pushes its remaining subranges. Each
//   result beat is read from the element ram; a stalled beat holds steady.
// reset:
//   rst_n clears the queue, element count and range stack depth; element
//   and stack ram contents are not cleared and are never read unwritten.
module quicksort_engine import qs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    queue_head_t head;
    logic        pop;

    // front: accepts beats into the queue
    qs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .head       (head),
        .pop        (pop)
    );

    // back: store, sort, stream out
    qs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/qs_ram.sv
// qs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module qs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/qs_front.sv
// qs_front: accepts input beats into a two-entry queue for the back end
// depends on qs_pkg
module qs_front import qs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output queue_head_t head,
    input  logic        pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       take;

    assign item_stall = (fill_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign take       = pop && (fill_reg != 2'd0);

    assign head.valid = (fill_reg != 2'd0);
    assign head.data  = entry_reg[rd_ptr_reg];

    // queue pointers and storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            entry_reg[0] <= '0;
            entry_reg[1] <= '0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= item;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, take})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

>>> rtl/qs_back.sv
// qs_back: stores elements, sorts them with quicksort and streams them out
// depends on qs_pkg and qs_ram
module qs_back import qs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    typedef enum logic [4:0] {
        S_LOAD, S_START, S_POP, S_POPW, S_PIV, S_PIVW,
        S_I, S_IW, S_J, S_JW, S_DEC, S_SW2, S_FIN, S_PUSH1, S_PUSH2,
        S_EMIT_RD, S_EMIT_W, S_EMIT_HOLD
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       depth_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [IDX_W-1:0]       lo_reg, hi_reg, i_reg, j_reg;
    logic [DATA_WIDTH-1:0]  pivot_reg, a_reg, b_reg;
    logic                   out_valid_reg;
    result_t                out_reg;

    logic                   st_we;
    logic [IDX_W-1:0]       st_waddr, st_raddr;
    logic [DATA_WIDTH-1:0]  st_wdata, st_rdata;
    logic                   sk_we;
    logic [IDX_W-1:0]       sk_waddr, sk_raddr;
    logic [STK_W-1:0]       sk_wdata, sk_rdata;

    logic                   has_room;
    logic                   push_low;
    logic                   push_high;
    logic                   k_last;

    assign has_room  = (depth_reg < CNT_W'(MAX_ELEMS));
    assign push_low  = ({1'b0, j_reg} > ({1'b0, lo_reg} + CNT_W'(1))) && has_room;
    assign push_high = (({1'b0, j_reg} + CNT_W'(1)) < {1'b0, hi_reg}) && has_room;
    assign k_last    = ((k_reg + CNT_W'(1)) == count_reg);

    assign pop          = (state_reg == S_LOAD) && head.valid;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    qs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    qs_ram #(.WIDTH(STK_W), .DEPTH(MAX_ELEMS)) u_stack (
        .clk   (clk),
        .we    (sk_we),
        .waddr (sk_waddr),
        .wdata (sk_wdata),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    // memory port control
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = i_reg;
        st_wdata = b_reg;
        st_raddr = i_reg;
        sk_we    = 1'b0;
        sk_waddr = depth_reg[IDX_W-1:0];
        sk_wdata = {lo_reg, IDX_W'(j_reg - IDX_W'(1))};
        sk_raddr = IDX_W'(depth_reg - CNT_W'(1));
        case (state_reg)
            S_LOAD:
            begin
                st_we    = head.valid && (count_reg < CNT_W'(MAX_ELEMS));
                st_waddr = count_reg[IDX_W-1:0];
                st_wdata = head.data.value;
            end
            S_START:
            begin
                sk_we    = 1'b1;
                sk_waddr = '0;
                sk_wdata = {IDX_W'(0), IDX_W'(count_reg - CNT_W'(1))};
            end
            S_PIV:     st_raddr = lo_reg;
            S_I:       st_raddr = i_reg;
            S_J:       st_raddr = j_reg;
            S_DEC:
            begin
                st_we    = 1'b1;
                st_waddr = (i_reg < j_reg) ? i_reg : lo_reg;
                st_wdata = b_reg;
            end
            S_SW2:
            begin
                st_we    = 1'b1;
                st_waddr = j_reg;
                st_wdata = a_reg;
            end
            S_FIN:
            begin
                st_we    = 1'b1;
                st_waddr = j_reg;
                st_wdata = pivot_reg;
            end
            S_PUSH1:   sk_we = push_low;
            S_PUSH2:
            begin
                sk_we    = push_high;
                sk_wdata = {IDX_W'(j_reg + IDX_W'(1)), hi_reg};
            end
            S_EMIT_RD: st_raddr = k_reg[IDX_W-1:0];
            default:   st_we = 1'b0;
        endcase
    end

    // sequencer: load, partition loop, range stack, streaming out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            depth_reg     <= '0;
            k_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            pivot_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (head.valid)
                    begin
                        if (count_reg < CNT_W'(MAX_ELEMS))
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (head.data.last_element)
                        begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    k_reg <= '0;
                    if (count_reg < CNT_W'(2))
                    begin
                        depth_reg <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        depth_reg <= CNT_W'(1);
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (depth_reg == '0)
                    begin
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - CNT_W'(1);
                        state_reg <= S_POPW;
                    end
                end
                S_POPW:
                begin
                    lo_reg    <= sk_rdata[STK_W-1:IDX_W];
                    hi_reg    <= sk_rdata[IDX_W-1:0];
                    state_reg <= S_PIV;
                end
                S_PIV:     state_reg <= S_PIVW;
                S_PIVW:
                begin
                    pivot_reg <= st_rdata;
                    i_reg     <= lo_reg;
                    j_reg     <= hi_reg;
                    state_reg <= S_I;
                end
                // left scan, bounded at the range's high index
                S_I:       state_reg <= (i_reg < hi_reg) ? S_IW : S_J;
                S_IW:
                begin
                    if ($signed(st_rdata) <= $signed(pivot_reg))
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_I;
                    end
                    else
                    begin
                        a_reg     <= st_rdata;
                        state_reg <= S_J;
                    end
                end
                // right scan
                S_J:
                begin
                    if (j_reg > lo_reg)
                    begin
                        state_reg <= S_JW;
                    end
                    else
                    begin
                        b_reg     <= pivot_reg;
                        state_reg <= S_DEC;
                    end
                end
                S_JW:
                begin
                    if ($signed(st_rdata) > $signed(pivot_reg))
                    begin
                        j_reg     <= j_reg - IDX_W'(1);
                        state_reg <= S_J;
                    end
                    else
                    begin
                        b_reg     <= st_rdata;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:     state_reg <= (i_reg < j_reg) ? S_SW2 : S_FIN;
                S_SW2:     state_reg <= S_I;
                S_FIN:     state_reg <= S_PUSH1;
                S_PUSH1:
                begin
                    if (push_low)
                    begin
                        depth_reg <= depth_reg + CNT_W'(1);
                    end
                    state_reg <= S_PUSH2;
                end
                S_PUSH2:
                begin
                    if (push_high)
                    begin
                        depth_reg <= depth_reg + CNT_W'(1);
                    end
                    state_reg <= S_POP;
                end
                // stream the sorted set out, one beat at a time
                S_EMIT_RD: state_reg <= S_EMIT_W;
                S_EMIT_W:
                begin
                    out_reg.sorted_value <= st_rdata;
                    out_reg.last_result  <= k_last;
                    out_valid_reg        <= 1'b1;
                    state_reg            <= S_EMIT_HOLD;
                end
                S_EMIT_HOLD:
                begin
                    if (!result_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (k_last)
                        begin
                            count_reg <= '0;
                            k_reg     <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CNT_W'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:   state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

>>> sim/quicksort_engine_tb.sv
// quicksort_engine_tb: self-checking bench for the quicksort engine
// depends on qs_pkg and the quicksort_engine rtl; sorted sets are predicted in the bench
module quicksort_engine_tb;
    import qs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard: collects the open set and queues its sorted beats
    class sort_scoreboard;
        logic signed [DATA_WIDTH-1:0] set_vals[$];
        result_t                      sorted_q[$];
        int                           mismatches;

        function void note_item(item_t it);
            logic signed [DATA_WIDTH-1:0] tmp;
            int n;
            if (set_vals.size() < MAX_ELEMS)
                set_vals.push_back(it.value);
            if (it.last_element)
            begin
                // stable order is irrelevant for equal values, plain signed sort
                n = set_vals.size();
                for (int a = 1; a < n; a++)
                begin
                    tmp = set_vals[a];
                    for (int b = a - 1; b >= 0 && set_vals[b] > tmp; b--)
                    begin
                        set_vals[b + 1] = set_vals[b];
                        set_vals[b] = tmp;
                    end
                end
                for (int k = 0; k < n; k++)
                    sorted_q.push_back('{sorted_value: set_vals[k],
                                         last_result: (k == n - 1)});
                set_vals.delete();
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (sorted_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %0d last %0b",
                             got.sorted_value, got.last_result);
                return;
            end
            want = sorted_q.pop_front();
            if (got.sorted_value !== want.sorted_value || got.last_result !== want.last_result)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0b got %0d/%0b",
                             want.sorted_value, want.last_result,
                             got.sorted_value, got.last_result);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    sort_scoreboard sb;
    logic           hold_receiver;
    int             idle_cycles;

    quicksort_engine uut (.*);

    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom();
        endcase
    endfunction

    // offer one beat and hold it until taken; valid stays up after the
    // accepting edge and is dropped by the next gap or by wait_drained
    task automatic send_beat(logic signed [DATA_WIDTH-1:0] v, logic lst, bit nogap);
        int g;
        g = nogap ? 0 : gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{value: v, last_element: lst};
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sb.note_item('{value: v, last_element: lst});
    endtask

    task automatic send_set(int n, bit nogap);
        for (int k = 0; k < n; k++)
            send_beat(rand_value(), k == n - 1, nogap);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.sorted_q.size() != 0) @(posedge clk);
    endtask

    // receiver stall pattern, with an optional long hold-off
    initial
    begin
        int g;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_receiver)
            begin
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            g = gap_len();
            if ($urandom_range(0, 3) == 0) g = 0;
            result_stall <= (g != 0);
            repeat (g > 0 ? g : 1) @(posedge clk);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // watchdog on cycles without progress
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("[quicksort_engine] ERROR");
            $finish;
        end
    end

    initial
    begin
        sb            = new();
        idle_cycles   = 0;
        hold_receiver = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single, pair, extremes, duplicates, sorted and reversed
        send_beat(5, 1'b1, 1'b0);
        send_beat({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0, 1'b0);
        send_beat({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1, 1'b0);
        for (int k = 0; k < 4; k++) send_beat(-7, k == 3, 1'b0);
        for (int k = 0; k < 5; k++) send_beat(k - 2, k == 4, 1'b0);
        for (int k = 0; k < 5; k++) send_beat(10 - k, k == 4, 1'b1);
        send_beat(-1, 1'b0, 1'b0);
        send_beat(0, 1'b1, 1'b0);
        wait_drained();

        // full store plus overflow beats that get dropped
        for (int k = 0; k < MAX_ELEMS + 3; k++)
            send_beat(rand_value(), k == MAX_ELEMS + 2, 1'b1);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_receiver = 1'b1;
        send_set(8, 1'b1);
        send_set(6, 1'b1);
        send_set(4, 1'b1);
        wait_drained();

        // a few random small sets
        while (sb.mismatches >= 0)
        begin
            static int total = 0;
            int n;
            n = $urandom_range(1, 10);
            send_set(n, 1'b0);
            total += n;
            if (total >= 10) break;
        end
        wait_drained();
        repeat (50) @(posedge clk);

        if (sb.mismatches == 0 && sb.sorted_q.size() == 0)
            $display("[quicksort_engine] OK");
        else
            $display("[quicksort_engine] ERROR");
        $finish;
    end
endmodule

>>> quicksort_engine.f
rtl/qs_pkg.sv
rtl/qs_ram.sv
rtl/qs_front.sv
rtl/qs_back.sv
rtl/quicksort_engine.sv
sim/quicksort_engine_tb.sv
